// File: design/krt_pkg.sv
// Shared types and codes for the keyed record table.
// No dependencies; imported by krt_ctrl, krt_dpath, keyed_record_table_core and tb_top.
package krt_pkg;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 16;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 20;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_PRICE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_QTY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_BOTH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OVERWRITE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_UPDATED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DELETED   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } krt_rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHIFT,
    S_RESP
  } krt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_en;
    logic shift_start;
    logic shift_en;
    logic wr_update;
    logic wr_append;
    logic cnt_inc;
    logic cnt_dec;
  } krt_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             found;
    logic             full;
    logic             scan_done;
    logic             shift_done;
  } krt_sts_t;

endpackage

// File: design/krt_ctrl.sv
// Controller state machine for the keyed record table.
// Depends on krt_pkg; drives krt_dpath through krt_ctl_t.
module krt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  krt_pkg::krt_sts_t           sts,
  output krt_pkg::krt_ctl_t           ctl,
  output logic                        busy,
  output logic                        done,
  output logic [krt_pkg::STAT_W-1:0]  status
);
  import krt_pkg::*;

  krt_state_t        state, state_next;
  logic [STAT_W-1:0] status_q, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= STAT_NOT_FOUND;
    end else begin
      state    <= state_next;
      status_q <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status_q;
    ctl         = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (sts.scan_done) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next  = S_RESP;
        status_next = STAT_NOT_FOUND;
        unique case (sts.cmd)
          CMD_ADD: begin
            if (sts.found) begin
              ctl.wr_update = 1'b1;
              status_next   = STAT_OVERWRITE;
            end else if (sts.full) begin
              status_next = STAT_FULL;
            end else begin
              ctl.wr_append = 1'b1;
              ctl.cnt_inc   = 1'b1;
              status_next   = STAT_ADDED;
            end
          end
          CMD_SET_PRICE, CMD_SET_QTY, CMD_SET_BOTH: begin
            if (sts.found) begin
              ctl.wr_update = 1'b1;
              status_next   = STAT_UPDATED;
            end
          end
          CMD_DELETE: begin
            if (sts.found) begin
              ctl.shift_start = 1'b1;
              state_next      = S_SHIFT;
            end
          end
          default: status_next = STAT_NOT_FOUND;
        endcase
      end
      S_SHIFT: begin
        ctl.shift_en = 1'b1;
        if (sts.shift_done) begin
          ctl.cnt_dec = 1'b1;
          status_next = STAT_DELETED;
          state_next  = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_RESP);
  assign status = status_q;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_done_not_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a transaction in flight");

endmodule

// File: design/krt_dpath.sv
// Datapath for the keyed record table: record memory, scan/shift pointer, count.
// Depends on krt_pkg; controlled by krt_ctrl.
module krt_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  krt_pkg::krt_ctl_t            ctl,
  input  logic [krt_pkg::CMD_W-1:0]    cmd,
  input  logic [krt_pkg::KEY_W-1:0]    key,
  input  logic [krt_pkg::PRICE_W-1:0]  price,
  input  logic [krt_pkg::QTY_W-1:0]    quantity,
  output krt_pkg::krt_sts_t            sts,
  output logic [krt_pkg::COUNT_W-1:0]  count
);
  import krt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  krt_rec_t mem [CAPACITY];

  // latched request
  logic [CMD_W-1:0]   req_cmd;
  krt_rec_t           req;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   ptr;      // next address to read
  logic [CNT_W-1:0]   rd_ptr;   // address of the data in rd_data
  logic               rd_valid;
  krt_rec_t           rd_data;
  logic               found;
  logic [CNT_W-1:0]   pos;
  krt_rec_t           hit_rec;

  logic               issue;
  logic               match;
  logic               sh_wr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [CNT_W-1:0]   sh_dst;
  krt_rec_t           wr_data;
  krt_rec_t           upd_rec;

  assign issue = ((ctl.scan_en && !found) || ctl.shift_en) && (ptr < cnt);
  assign match = ctl.scan_en && rd_valid && !found && (rd_data.key == req.key);
  assign sh_wr = ctl.shift_en && rd_valid;
  assign sh_dst = rd_ptr - CNT_W'(1);

  // merge for overwrite / set commands
  always_comb begin
    upd_rec = hit_rec;
    if (req_cmd == CMD_SET_PRICE || req_cmd == CMD_SET_BOTH) upd_rec.price = req.price;
    if (req_cmd != CMD_SET_PRICE) upd_rec.qty = req.qty;
  end

  always_comb begin
    wr_en   = ctl.wr_update || ctl.wr_append || sh_wr;
    wr_addr = pos[IDX_W-1:0];
    wr_data = upd_rec;
    priority if (ctl.wr_append) begin
      wr_addr = cnt[IDX_W-1:0];
      wr_data = req;
    end else if (sh_wr) begin
      wr_addr = sh_dst[IDX_W-1:0];
      wr_data = rd_data;
    end else begin
      wr_addr = pos[IDX_W-1:0];
      wr_data = upd_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_data <= mem[ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd   <= cmd;
      req.key   <= key;
      req.price <= price;
      req.qty   <= quantity;
    end
    if (match) begin
      pos     <= rd_ptr;
      hit_rec <= rd_data;
    end
    if (issue) rd_ptr <= ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      ptr      <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (ctl.load) begin
        ptr   <= '0;
        found <= 1'b0;
      end else if (ctl.shift_start) begin
        ptr <= pos + CNT_W'(1);
      end else if (issue) begin
        ptr <= ptr + CNT_W'(1);
      end
      if (match) found <= 1'b1;
      if (ctl.cnt_inc) cnt <= cnt + CNT_W'(1);
      else if (ctl.cnt_dec) cnt <= cnt - CNT_W'(1);
    end
  end

  assign sts.cmd        = req_cmd;
  assign sts.found      = found;
  assign sts.full       = (cnt >= CNT_W'(CAPACITY));
  assign sts.scan_done  = found || ((ptr >= cnt) && !rd_valid);
  assign sts.shift_done = (ptr >= cnt) && !rd_valid;
  assign count          = COUNT_W'(cnt);

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY)) else $error("record count above capacity");
  a_append_miss: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_inc |-> (!found && !sts.full)) else $error("append on hit or full table");
  a_delete_hit: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_dec |-> (found && cnt != '0)) else $error("delete without a matched record");
  a_shift_dst: assert property (@(posedge clk) disable iff (rst)
    sh_wr |-> (sh_dst >= pos && sh_dst < cnt)) else $error("shift write out of range");

endmodule

// File: design/keyed_record_table_core.sv
// Top level of the keyed record table: controller plus datapath; needs krt_pkg.
// A transaction searches the records with one read per search step; a delete
// searches to the hit, then closes the gap. One transaction at a time, next
// accept in the cycle after done. Reset (rst, sync): count zero, idle;
// memory not cleared. done strobes one cycle; the receiver cannot stall.
module keyed_record_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [krt_pkg::CMD_W-1:0]    cmd,
  input  logic [krt_pkg::KEY_W-1:0]    key,
  input  logic [krt_pkg::PRICE_W-1:0]  price,
  input  logic [krt_pkg::QTY_W-1:0]    quantity,
  output logic                         done,
  output logic [krt_pkg::STAT_W-1:0]   status,
  output logic [krt_pkg::COUNT_W-1:0]  count
);
  import krt_pkg::*;

  // command / status bundles between the controller and the datapath
  krt_ctl_t ctl;
  krt_sts_t sts;

  // Controller: IDLE -> SCAN (search) -> EXEC (decide, write) ->
  // optional SHIFT (delete gap close) -> RESP (one-cycle result strobe).
  krt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  // Datapath: single-port-write / single-read record memory with a
  // registered read, shared scan/shift pointer and the record count.
  krt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cmd      (cmd),
    .key      (key),
    .price    (price),
    .quantity (quantity),
    .sts      (sts),
    .count    (count)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for keyed_record_table_core: directed and random command transactions,
// every done strobe checked against a behavioral model of the record table.
// Depends on krt_pkg and keyed_record_table_core.
module tb_top;
  import krt_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int MAX_GAP        = 19;
  // worst transaction is a delete on a full table
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MIXED_ITEMS    = 300;
  localparam int KEY_POOL_SIZE  = 96;

  // unused command codes; the block must ignore them and report not found
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  logic [CMD_W-1:0]   cmd      = '0;
  logic [KEY_W-1:0]   key      = '0;
  logic [PRICE_W-1:0] price    = '0;
  logic [QTY_W-1:0]   quantity = '0;
  logic               busy;
  logic               done;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] count;

  // model copy of the table; only entries below tbl_count are meaningful
  logic [KEY_W-1:0]   tbl_keys   [CAPACITY];
  logic [PRICE_W-1:0] tbl_prices [CAPACITY];
  logic [QTY_W-1:0]   tbl_qtys   [CAPACITY];
  int                 tbl_count = 0;

  table_result_t      expected_results [$];
  logic [KEY_W-1:0]   key_pool [KEY_POOL_SIZE];
  int                 error_count  = 0;
  int                 quiet_cycles = 0;
  int                 burst_left   = 0;

  keyed_record_table_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .key      (key),
    .price    (price),
    .quantity (quantity),
    .done     (done),
    .status   (status),
    .count    (count)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  // slot of the record holding k, or tbl_count on a miss (keys are unique)
  function automatic int find_slot(input logic [KEY_W-1:0] k);
    int pos;
    pos = tbl_count;
    for (int i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_keys[i] == k) pos = i;
    end
    return pos;
  endfunction

  function automatic bit is_held(input logic [KEY_W-1:0] k);
    return find_slot(k) < tbl_count;
  endfunction

  // applies one accepted command to the model table and returns status/count
  function automatic table_result_t apply_command(input logic [CMD_W-1:0] c,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [PRICE_W-1:0] p,
                                                  input logic [QTY_W-1:0] q);
    table_result_t r;
    int pos;
    pos = find_slot(k);
    r.status = STAT_NOT_FOUND;
    case (c)
      CMD_ADD: begin
        if (pos < tbl_count) begin
          // existing key: quantity only, price of the command is dropped
          tbl_qtys[pos] = q;
          r.status = STAT_OVERWRITE;
        end else if (tbl_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          tbl_keys[tbl_count]   = k;
          tbl_prices[tbl_count] = p;
          tbl_qtys[tbl_count]   = q;
          tbl_count++;
          r.status = STAT_ADDED;
        end
      end
      CMD_SET_PRICE, CMD_SET_QTY, CMD_SET_BOTH: begin
        if (pos < tbl_count) begin
          if (c != CMD_SET_QTY) tbl_prices[pos] = p;
          if (c != CMD_SET_PRICE) tbl_qtys[pos] = q;
          r.status = STAT_UPDATED;
        end
      end
      CMD_DELETE: begin
        if (pos < tbl_count) begin
          // close the gap, later records move down one slot
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_keys[i]   = tbl_keys[i + 1];
            tbl_prices[i] = tbl_prices[i + 1];
            tbl_qtys[i]   = tbl_qtys[i + 1];
          end
          tbl_count--;
          r.status = STAT_DELETED;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(tbl_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Key and command pickers
  // ---------------------------------------------------------------------------

  function automatic logic [KEY_W-1:0] held_key();
    if (tbl_count == 0) return KEY_W'($urandom);
    return tbl_keys[$urandom_range(0, tbl_count - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = KEY_W'($urandom); while (is_held(k));
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
  endfunction

  function automatic logic [CMD_W-1:0] random_set_cmd();
    return CMD_W'($urandom_range(CMD_SET_PRICE, CMD_SET_BOTH));
  endfunction

  function automatic logic [CMD_W-1:0] random_rsvd_cmd();
    return CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Drives one command transaction and records its expected result at the
  // edge where it is taken (start high, busy low). start is left high so a
  // back-to-back transaction needs no drop; any pause lowers it first.
  task automatic send_command(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                              input logic [PRICE_W-1:0] p, input logic [QTY_W-1:0] q);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(4, 24);
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    cmd      <= c;
    key      <= k;
    price    <= p;
    quantity <= q;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_results.push_back(apply_command(c, k, p, q));
  endtask

  task automatic send_random(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
    send_command(c, k, PRICE_W'($urandom), QTY_W'($urandom));
  endtask

  // stop sending and hold off until every outstanding result has come back
  task automatic wait_all_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // field extremes, every command, hits and misses, unused codes, empty table
  task automatic test_directed();
    send_command(CMD_ADD, 16'h0000, 32'h0000_0000, 20'h00000);
    send_command(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF);
    send_command(CMD_ADD, 16'h0000, 32'h1234_5678, 20'h00005);  // quantity overwrite
    send_command(CMD_SET_PRICE, 16'hFFFF, 32'h0000_0000, 20'h00000);
    send_command(CMD_SET_QTY, 16'h0000, 32'hFFFF_FFFF, 20'hFFFFF);
    send_command(CMD_SET_BOTH, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF);
    // misses on every update and on delete
    send_command(CMD_SET_PRICE, 16'h1234, 32'hAAAA_AAAA, 20'h55555);
    send_command(CMD_SET_QTY, 16'h1234, 32'h5555_5555, 20'hAAAAA);
    send_command(CMD_SET_BOTH, 16'h1234, 32'hAAAA_AAAA, 20'hAAAAA);
    send_command(CMD_DELETE, 16'h1234, 32'h0000_0000, 20'h00000);
    // unused codes addressed at a held key: nothing may change
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) begin
      send_command(CMD_W'(c), 16'h0000, 32'hFFFF_FFFF, 20'hFFFFF);
    end
    send_command(CMD_ADD, 16'h8000, 32'h8000_0000, 20'h80000);
    send_command(CMD_DELETE, 16'h0000, 32'h0000_0000, 20'h00000);  // first slot, gap closed
    send_command(CMD_SET_BOTH, 16'h8000, 32'h0000_0001, 20'h00001);  // moved record
    send_command(CMD_DELETE, 16'h8000, 32'h0000_0000, 20'h00000);  // last slot
    send_command(CMD_DELETE, 16'hFFFF, 32'h0000_0000, 20'h00000);  // table now empty
    // commands on an empty table
    send_command(CMD_DELETE, 16'hFFFF, 32'h0000_0000, 20'h00000);
    send_command(CMD_SET_PRICE, 16'h0000, 32'h1111_1111, 20'h11111);
    send_command(CMD_RSVD_LAST, 16'h0000, 32'h0000_0000, 20'h00000);
    send_command(CMD_ADD, 16'h5555, 32'hAAAA_AAAA, 20'h55555);
    wait_all_results();
  endtask

  // grow to capacity with updates mixed in, then probe the full table
  task automatic test_fill_to_capacity();
    while (tbl_count < CAPACITY) begin
      if ($urandom_range(0, 3) == 0) send_random(random_set_cmd(), held_key());
      else send_random(CMD_ADD, fresh_key());
    end
    repeat (12) begin
      case ($urandom_range(0, 3))
        0: send_random(CMD_ADD, fresh_key());         // table full
        1: send_random(CMD_ADD, held_key());          // overwrite still allowed
        2: send_random(random_set_cmd(), held_key());
        default: send_random(random_rsvd_cmd(), held_key());
      endcase
    end
    // free one slot, refill it, then hit full again
    send_random(CMD_DELETE, held_key());
    send_random(CMD_ADD, fresh_key());
    send_random(CMD_ADD, fresh_key());
    wait_all_results();
  endtask

  // empty the table from random positions, with misses and updates between
  task automatic test_drain();
    while (tbl_count > 0) begin
      case ($urandom_range(0, 9))
        0: send_random(CMD_DELETE, fresh_key());
        1: send_random(random_set_cmd(), held_key());
        default: send_random(CMD_DELETE, held_key());
      endcase
    end
    send_random(CMD_DELETE, KEY_W'($urandom));
    wait_all_results();
  endtask

  // Long random run over a limited key pool so adds, updates and deletes keep
  // hitting each other; adds are drawn more often than deletes.
  task automatic test_mixed();
    int sel;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    repeat (MIXED_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) c = CMD_ADD;
      else if (sel < 65) c = random_set_cmd();
      else if (sel < 92) c = CMD_DELETE;
      else c = random_rsvd_cmd();
      sel = $urandom_range(0, 9);
      if (c == CMD_ADD) begin
        if (sel < 5) k = pool_key();
        else if (sel < 8) k = KEY_W'($urandom);
        else k = held_key();
      end else begin
        if (sel < 6) k = held_key();
        else if (sel < 9) k = pool_key();
        else k = KEY_W'($urandom);
      end
      send_random(c, k);
      if ($urandom_range(0, 39) == 0) wait_all_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done strobe is a result transaction, in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status=%0d count=%0d", status, count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          error_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, count);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles with neither a command taken nor a result returned
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_to_capacity();
    test_drain();
    test_mixed();
    wait_all_results();
    // quiet tail: catches stray strobes after the last expected result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
